@@ sv/adwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adwc_pkg
// Types and constants shared by the anchor-delta word compressor.
// ----------------------------------------------------------------------------
package adwc_pkg;

    localparam int MAX_INPUT_WORDS = 1024;
    localparam int ANCHOR_COUNT    = 4;
    localparam int WORD_CAP_RAW    = (MAX_INPUT_WORDS * 34 + 31) / 32;
    localparam int WORD_CAP        = (WORD_CAP_RAW > 2047) ? 2047 : WORD_CAP_RAW;

    localparam logic [31:0] UPPER_MASK = 32'hFFFF_FC00;

    localparam logic [1:0] CODE_ZERO  = 2'b00;
    localparam logic [1:0] CODE_EXACT = 2'b01;
    localparam logic [1:0] CODE_UPPER = 2'b10;
    localparam logic [1:0] CODE_RAW   = 2'b11;

    localparam logic [5:0] LEN_ZERO  = 6'd2;
    localparam logic [5:0] LEN_EXACT = 6'd4;
    localparam logic [5:0] LEN_UPPER = 6'd14;
    localparam logic [5:0] LEN_RAW   = 6'd34;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] word_value;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] packed_word;
        logic        word_valid;
        logic        end_of_buffer;
        logic [12:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic [33:0] bits;
        logic [5:0]  len;
        logic        last;
    } t_code;

endpackage

@@ sv/adwc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adwc_front
// Keeps the anchor words and turns each input word into a variable-length code.
// ----------------------------------------------------------------------------
module adwc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  adwc_pkg::t_in_item i_item,
    output adwc_pkg::t_code   o_code
);
    import adwc_pkg::*;

    logic [31:0] r_anchor [ANCHOR_COUNT];
    logic [1:0]  r_newest;

    logic        hit;
    logic        hit_exact;
    logic [1:0]  hit_idx;
    logic [1:0]  idx;
    logic [1:0]  slot_new;
    logic [31:0] v;

    assign v        = i_item.word_value;
    assign slot_new = r_newest + 2'd1;

    always_comb begin
        hit       = 1'b0;
        hit_exact = 1'b0;
        hit_idx   = 2'd0;
        idx       = 2'd0;
        for (int k = 0; k < ANCHOR_COUNT; k++) begin
            idx = r_newest - 2'(k);
            if (!hit) begin
                if (r_anchor[idx] == v) begin
                    hit       = 1'b1;
                    hit_exact = 1'b1;
                    hit_idx   = idx;
                end else if ((r_anchor[idx] & UPPER_MASK) == (v & UPPER_MASK)) begin
                    hit     = 1'b1;
                    hit_idx = idx;
                end
            end
        end
    end

    always_comb begin
        o_code.last = i_item.is_last;
        if (v == 32'd0) begin
            o_code.bits = {32'd0, CODE_ZERO};
            o_code.len  = LEN_ZERO;
        end else if (hit && hit_exact) begin
            o_code.bits = {30'd0, hit_idx, CODE_EXACT};
            o_code.len  = LEN_EXACT;
        end else if (hit) begin
            o_code.bits = {20'd0, v[9:0], hit_idx, CODE_UPPER};
            o_code.len  = LEN_UPPER;
        end else begin
            o_code.bits = {v, CODE_RAW};
            o_code.len  = LEN_RAW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ANCHOR_COUNT; k++) begin
                r_anchor[k] <= 32'd0;
            end
            r_newest <= 2'd3;
        end else if (i_accept) begin
            if (i_item.is_last) begin
                for (int k = 0; k < ANCHOR_COUNT; k++) begin
                    r_anchor[k] <= 32'd0;
                end
                r_newest <= 2'd3;
            end else if (v != 32'd0) begin
                if (hit && !hit_exact) begin
                    r_anchor[hit_idx] <= v;
                end else if (!hit) begin
                    r_anchor[slot_new] <= v;
                    r_newest           <= slot_new;
                end
            end
        end
    end

endmodule

@@ sv/adwc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adwc_queue
// Short code queue between the classifier and the bit packer.
// ----------------------------------------------------------------------------
module adwc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  adwc_pkg::t_code  i_code,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output adwc_pkg::t_code  o_code
);
    import adwc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_code         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_code  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

@@ sv/adwc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adwc_back
// Packs codes LSB first into 32-bit words and holds the result register.
// ----------------------------------------------------------------------------
module adwc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  adwc_pkg::t_code     i_code,
    output logic                o_q_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output adwc_pkg::t_out_item o_item
);
    import adwc_pkg::*;

    logic [65:0] r_acc;
    logic [6:0]  r_cnt;
    logic        r_last;
    logic [10:0] r_words;
    logic        r_ovalid;
    t_out_item   r_out;

    logic [65:0] n_acc;
    logic [6:0]  n_cnt;
    logic        n_last;
    logic [10:0] n_words;

    logic        slot_ok;
    logic        emit_full;
    logic        emit_flush;
    logic        emit;
    logic        end_now;
    logic        last1;
    logic        absorb;
    logic [65:0] acc1;
    logic [6:0]  c1;
    logic [10:0] words_inc;

    assign slot_ok    = !r_ovalid || i_pop;
    assign emit_full  = slot_ok && (r_cnt >= 7'd32);
    assign emit_flush = slot_ok && r_last && (r_cnt != 7'd0) && (r_cnt < 7'd32);
    assign emit       = emit_full || emit_flush;
    assign words_inc  = (r_words < 11'(WORD_CAP)) ? r_words + 11'd1 : r_words;

    always_comb begin
        if (emit_full) begin
            acc1 = r_acc >> 32;
            c1   = r_cnt - 7'd32;
        end else if (emit_flush) begin
            acc1 = '0;
            c1   = 7'd0;
        end else begin
            acc1 = r_acc;
            c1   = r_cnt;
        end
        end_now = r_last && (emit_flush || (emit_full && (c1 == 7'd0)));
        last1   = r_last && !end_now;
        absorb  = !last1 && (c1 < 7'd32) && !i_q_empty;
        n_acc   = acc1;
        n_cnt   = c1;
        n_last  = last1;
        if (absorb) begin
            n_acc  = acc1 | ({32'd0, i_code.bits} << c1[4:0]);
            n_cnt  = c1 + {1'b0, i_code.len};
            n_last = i_code.last;
        end
        if (end_now) begin
            n_words = 11'd0;
        end else if (emit) begin
            n_words = words_inc;
        end else begin
            n_words = r_words;
        end
    end

    assign o_q_rd  = absorb;
    assign o_empty = !r_ovalid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_words  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_words <= n_words;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.packed_word   <= r_acc[31:0];
            r_out.word_valid    <= 1'b1;
            r_out.end_of_buffer <= end_now;
            r_out.byte_count    <= {words_inc, 2'b00};
        end
    end

endmodule

@@ sv/anchor_delta_word_compressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_delta_word_compressor
// Four-anchor word compressor with an LSB-first packed output stream.
// ----------------------------------------------------------------------------
// The block accepts one input word per cycle while its code queue has room.
// The classifier compares the word with all four anchors in parallel and
// queues a 2, 4, 14 or 34 bit code; the packer absorbs one code per cycle
// while it holds fewer than 32 bits and no word marked last is pending, and
// delivers at most one packed word per cycle through its result register.
// Input and output rates therefore match except where the result stream
// limits: a raw-word code yields at least one packed word, and a word marked
// last holds back the next code until its final packed word is delivered,
// after which all state returns to its reset value for the next buffer.
module anchor_delta_word_compressor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  adwc_pkg::t_in_item  i_data,
    output logic                empty,
    input  logic                pop,
    output adwc_pkg::t_out_item o_data
);
    import adwc_pkg::*;

    t_code fr_code;
    t_code q_code;
    logic  q_empty;
    logic  q_rd;
    logic  accept;

    assign accept = push && !full;

    adwc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_code   (fr_code)
    );

    adwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_code  (fr_code),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_code  (q_code)
    );

    adwc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_code    (q_code),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_data)
    );

endmodule

@@ verif/anchor_delta_word_compressor_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_delta_word_compressor_test
// Self-checking testbench for the four-anchor word compressor.
// ----------------------------------------------------------------------------
// A scoreboard predicts every packed word, end-of-buffer flag and byte count
// from each accepted request. Directed buffers cover zero words, exact and
// upper codes, raw codes into each anchor slot, small words against the zero
// anchors and single-word buffers. Random buffers mix repeats, near repeats,
// small and raw words. Both sides idle at random, and the receiver stalls
// once for a long stretch.
// ----------------------------------------------------------------------------
module anchor_delta_word_compressor_test;
    import adwc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;

    class adwc_scoreboard;
        logic [31:0] anchors [ANCHOR_COUNT];
        logic [1:0]  newest;
        logic [31:0] acc_bits;
        int unsigned acc_count;
        int unsigned words_out;
        t_out_item   packed_q [$];
        int          errors;

        function new();
            errors = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (anchors[k]) anchors[k] = '0;
            newest    = 2'd3;
            acc_bits  = '0;
            acc_count = 0;
            words_out = 0;
        endfunction

        function void emit_word(logic [31:0] w);
            t_out_item res;
            if (words_out < WORD_CAP) words_out++;
            res.packed_word   = w;
            res.word_valid    = 1'b1;
            res.end_of_buffer = 1'b0;
            res.byte_count    = 13'(words_out * 4);
            packed_q.push_back(res);
        endfunction

        function void append_code(logic [31:0] bits, int unsigned nbits);
            logic [63:0] acc;
            int unsigned cnt;
            acc = {32'd0, acc_bits} | ({32'd0, bits} << acc_count);
            cnt = acc_count + nbits;
            if (cnt >= 32) begin
                emit_word(acc[31:0]);
                acc = acc >> 32;
                cnt = cnt - 32;
            end
            acc_bits  = acc[31:0];
            acc_count = cnt;
        endfunction

        function void note_request(t_in_item req);
            logic [31:0] v;
            logic [1:0]  a;
            bit          hit;
            int          start;
            t_out_item   tail;
            v     = req.word_value;
            hit   = 1'b0;
            start = packed_q.size();
            if (v == '0) begin
                append_code({30'd0, CODE_ZERO}, LEN_ZERO);
            end else begin
                a = newest;
                for (int k = 0; k < ANCHOR_COUNT && !hit; k++) begin
                    if (anchors[a] == v) begin
                        append_code({28'd0, a, CODE_EXACT}, LEN_EXACT);
                        hit = 1'b1;
                    end else if ((anchors[a] & UPPER_MASK) == (v & UPPER_MASK)) begin
                        append_code({18'd0, v[9:0], a, CODE_UPPER}, LEN_UPPER);
                        anchors[a] = v;
                        hit = 1'b1;
                    end else begin
                        a = a - 2'd1;
                    end
                end
                if (!hit) begin
                    newest = newest + 2'd1;
                    anchors[newest] = v;
                    append_code({30'd0, CODE_RAW}, 2);
                    append_code(v, 32);
                end
            end
            if (req.is_last) begin
                if (acc_count > 0) emit_word(acc_bits);
                if (packed_q.size() == start) begin
                    tail.packed_word   = '0;
                    tail.word_valid    = 1'b0;
                    tail.end_of_buffer = 1'b0;
                    tail.byte_count    = 13'(words_out * 4);
                    packed_q.push_back(tail);
                end
                tail = packed_q.pop_back();
                tail.end_of_buffer = 1'b1;
                packed_q.push_back(tail);
                clear_buffer();
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (packed_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = packed_q.pop_front();
            if (got.packed_word !== exp.packed_word) begin
                $display("%0t: packed_word expected %h actual %h",
                         $time, exp.packed_word, got.packed_word);
                errors++;
            end
            if (got.word_valid !== exp.word_valid) begin
                $display("%0t: word_valid expected %b actual %b",
                         $time, exp.word_valid, got.word_valid);
                errors++;
            end
            if (got.end_of_buffer !== exp.end_of_buffer) begin
                $display("%0t: end_of_buffer expected %b actual %b",
                         $time, exp.end_of_buffer, got.end_of_buffer);
                errors++;
            end
            if (got.byte_count !== exp.byte_count) begin
                $display("%0t: byte_count expected %0d actual %0d",
                         $time, exp.byte_count, got.byte_count);
                errors++;
            end
        endfunction

        function int outstanding();
            return packed_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  in_req;
    logic      empty;
    logic      pop;
    t_out_item out_res;

    adwc_scoreboard book;
    bit          send_idle;
    bit          recv_idle;
    int          cycle_count;
    int          results_seen;
    logic [31:0] recent [8];
    int          recent_ptr;

    anchor_delta_word_compressor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (in_req),
        .empty   (empty),
        .pop     (pop),
        .o_data  (out_res)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] w, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   = 1'b1;
        in_req = '{word_value: w, is_last: last};
        do @(posedge i_clk); while (full);
        book.note_request(in_req);
        recent[recent_ptr] = w;
        recent_ptr = (recent_ptr + 1) % 8;
    endtask

    function automatic logic [31:0] pick_word();
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        w = recent[$urandom_range(0, 7)];
        if (r < 12) return '0;
        if (r < 38) return w;
        if (r < 62) return {w[31:10], 10'($urandom)};
        if (r < 72) return {22'd0, 10'($urandom)};
        return $urandom;
    endfunction

    initial begin
        pop = 1'b0;
        results_seen = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            int gap;
            gap = recv_idle ? $urandom_range(0, 6) : 0;
            @(negedge i_clk);
            if (results_seen == 40) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            book.check_result(out_res);
            results_seen++;
        end
    end

    initial begin
        int sent;
        int len;
        book        = new();
        recent_ptr  = 0;
        foreach (recent[k]) recent[k] = $urandom;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        push      = 1'b0;
        in_req    = '0;
        i_rst_n   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_03FF, 1'b0);
        send_word(32'h0000_03FF, 1'b0);
        send_word(32'h0000_0005, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FC00, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h9ABC_DEF0, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h1234_5679, 1'b0);
        send_word(32'h9ABC_DEF0, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0200, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);

        sent = 0;
        while (sent < 190) begin
            len       = $urandom_range(1, 24);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++) begin
                send_word(pick_word(), k == len - 1);
            end
            sent += len;
        end

        @(negedge i_clk);
        push = 1'b0;
        while (book.outstanding() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
